// ===== rtl/core/sgf_pkg.sv =====
package sgf_pkg;

  localparam int COEF_BITS    = 16;
  localparam int COEF_FRAC    = 14;
  localparam int HW_BITS      = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int NUM_DIST     = 6;
  localparam int HALF_WIDTH_MIN = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_COEF_CENTER = 3'd1,
    REG_COEF_DIST1  = 3'd2,
    REG_COEF_DIST2  = 3'd3,
    REG_COEF_DIST3  = 3'd4,
    REG_COEF_DIST4  = 3'd5,
    REG_COEF_DIST5  = 3'd6,
    REG_COEF_DIST6  = 3'd7
  } cfg_reg_t;

  localparam logic [HW_BITS-1:0] HALF_WIDTH_RESET = 3'd2;
  localparam logic signed [COEF_BITS-1:0] COEF_CENTER_RESET = 16'sd7958;
  localparam logic signed [COEF_BITS-1:0] COEF_DIST_RESET [NUM_DIST] = '{
    16'sd5617, -16'sd1404, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  typedef struct packed {
    logic filtered;
    logic last;
  } job_flags_t;

endpackage

// ===== rtl/core/sgf_ctrl.sv =====
module sgf_ctrl #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_HALF_WIDTH = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [sgf_pkg::HW_BITS-1:0]            half_width,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  input  logic                                   end_of_series,
  output logic                                   job_valid,
  input  logic                                   job_ready,
  output sgf_pkg::job_flags_t                    job_flags,
  output logic signed [SAMPLE_BITS-1:0]          job_raw,
  output logic signed [SAMPLE_BITS-1:0]          job_center,
  output logic signed [SAMPLE_BITS:0]            job_psum [MAX_HALF_WIDTH]
);

  localparam int HIST  = 2 * MAX_HALF_WIDTH + 1;
  localparam int CNT_W = $clog2(HIST + 1);
  localparam int HWB   = sgf_pkg::HW_BITS;

  logic signed [SAMPLE_BITS-1:0] hist [HIST];
  logic [CNT_W-1:0]              count;
  logic                          filt_pend;
  logic [HWB-1:0]                raw_cnt;
  logic                          seq_end;

  logic [HWB-1:0] h;
  logic [HWB:0]   cnt_x;
  logic [HWB:0]   h_x;
  logic [HWB:0]   two_h;
  logic           lt_h;
  logic           lt_2h;
  logic [HWB-1:0] held_raw;
  logic           new_filt;
  logic [HWB-1:0] new_raw;
  logic           busy;
  logic           final_job;
  logic           accept;
  logic           issue;

  always_comb begin
    if (half_width < HWB'(sgf_pkg::HALF_WIDTH_MIN)) begin
      h = HWB'(sgf_pkg::HALF_WIDTH_MIN);
    end else if (half_width > HWB'(MAX_HALF_WIDTH)) begin
      h = HWB'(MAX_HALF_WIDTH);
    end else begin
      h = half_width;
    end
  end

  always_comb begin
    cnt_x    = (HWB+1)'(count);
    h_x      = {1'b0, h};
    two_h    = {h, 1'b0};
    lt_h     = cnt_x < h_x;
    lt_2h    = cnt_x < two_h;
    held_raw = lt_h ? HWB'(1) : HWB'(cnt_x - h_x + (HWB+1)'(1));
    if (end_of_series) begin
      new_filt = !lt_2h;
      new_raw  = lt_2h ? held_raw : h;
    end else begin
      new_filt = !lt_2h;
      new_raw  = lt_h ? HWB'(1) : HWB'(0);
    end
  end

  assign busy      = filt_pend || (raw_cnt != '0);
  assign final_job = filt_pend ? (raw_cnt == '0) : (raw_cnt == HWB'(1));
  assign in_ready  = !busy || (job_ready && final_job);
  assign accept    = in_valid && in_ready;
  assign issue     = busy && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      filt_pend <= 1'b0;
      raw_cnt   <= '0;
      seq_end   <= 1'b0;
    end else begin
      if (issue) begin
        if (filt_pend) begin
          filt_pend <= 1'b0;
        end else begin
          raw_cnt <= raw_cnt - HWB'(1);
        end
      end
      if (accept) begin
        filt_pend <= new_filt;
        raw_cnt   <= new_raw;
        seq_end   <= end_of_series;
        if (end_of_series) begin
          count <= '0;
        end else if (count != CNT_W'(HIST)) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST; k++) begin
        hist[k] <= '0;
      end
    end else if (accept) begin
      hist[0] <= sample;
      for (int k = 1; k < HIST; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  always_comb begin
    job_valid          = busy;
    job_flags.filtered = filt_pend;
    job_flags.last     = !filt_pend && seq_end && (raw_cnt == HWB'(1));
    job_raw            = hist[0];
    for (int k = 0; k < MAX_HALF_WIDTH; k++) begin
      if (raw_cnt == HWB'(k + 1)) begin
        job_raw = hist[k];
      end
    end
    job_center = hist[sgf_pkg::HALF_WIDTH_MIN];
    for (int d = 0; d < MAX_HALF_WIDTH; d++) begin
      job_psum[d] = '0;
    end
    for (int k = sgf_pkg::HALF_WIDTH_MIN; k <= MAX_HALF_WIDTH; k++) begin
      if (h == HWB'(k)) begin
        job_center = hist[k];
        for (int d = 1; d <= k; d++) begin
          job_psum[d-1] = (SAMPLE_BITS+1)'(hist[k-d]) + (SAMPLE_BITS+1)'(hist[k+d]);
        end
      end
    end
  end

endmodule

// ===== rtl/core/sgf_mac.sv =====
module sgf_mac #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_HALF_WIDTH = 6
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic signed [sgf_pkg::COEF_BITS-1:0]      coef_center,
  input  logic signed [sgf_pkg::COEF_BITS-1:0]      coef_dist [MAX_HALF_WIDTH],
  input  logic                                      job_valid,
  output logic                                      job_ready,
  input  sgf_pkg::job_flags_t                       job_flags,
  input  logic signed [SAMPLE_BITS-1:0]             job_raw,
  input  logic signed [SAMPLE_BITS-1:0]             job_center,
  input  logic signed [SAMPLE_BITS:0]               job_psum [MAX_HALF_WIDTH],
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [SAMPLE_BITS-1:0]             smoothed_value,
  output logic                                      was_filtered,
  output logic                                      last_of_series
);

  localparam int W      = SAMPLE_BITS;
  localparam int M      = MAX_HALF_WIDTH;
  localparam int CB     = sgf_pkg::COEF_BITS;
  localparam int FRAC   = sgf_pkg::COEF_FRAC;
  localparam int P0_W   = W + CB;
  localparam int PD_W   = W + CB + 1;
  localparam int ACC_W  = W + CB + 3;
  localparam int NP     = (M + 2) / 2;
  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC - 1);

  logic                      v1;
  sgf_pkg::job_flags_t       f1;
  logic signed [W-1:0]       raw1;
  logic signed [W-1:0]       center1;
  logic signed [W:0]         psum1 [M];

  logic                      v2;
  sgf_pkg::job_flags_t       f2;
  logic signed [W-1:0]       raw2;
  logic signed [P0_W-1:0]    p0_2;
  logic signed [PD_W-1:0]    pd2 [M];

  logic                      v3;
  sgf_pkg::job_flags_t       f3;
  logic signed [W-1:0]       raw3;
  logic signed [ACC_W-1:0]   part3 [NP];

  logic                      rdy1;
  logic                      rdy2;
  logic                      rdy3;
  logic                      rdy_o;

  logic signed [ACC_W-1:0]   terms [2*NP];
  logic signed [ACC_W-1:0]   part_next [NP];
  logic signed [ACC_W-1:0]   total;
  logic signed [ACC_W-1:0]   rounded;
  logic signed [ACC_W-1:0]   quot;
  logic signed [W-1:0]       sat;

  assign rdy_o     = !out_valid || out_ready;
  assign rdy3      = !v3 || rdy_o;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign job_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= job_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_o) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      f1      <= job_flags;
      raw1    <= job_raw;
      center1 <= job_center;
      for (int d = 0; d < M; d++) begin
        psum1[d] <= job_psum[d];
      end
    end
    if (rdy2) begin
      f2   <= f1;
      raw2 <= raw1;
      p0_2 <= P0_W'(coef_center) * P0_W'(center1);
      for (int d = 0; d < M; d++) begin
        pd2[d] <= PD_W'(coef_dist[d]) * PD_W'(psum1[d]);
      end
    end
    if (rdy3) begin
      f3   <= f2;
      raw3 <= raw2;
      for (int j = 0; j < NP; j++) begin
        part3[j] <= part_next[j];
      end
    end
    if (rdy_o) begin
      was_filtered   <= f3.filtered;
      last_of_series <= f3.last;
      smoothed_value <= f3.filtered ? sat : raw3;
    end
  end

  always_comb begin
    for (int k = 0; k < 2*NP; k++) begin
      terms[k] = '0;
    end
    terms[0] = ACC_W'(p0_2);
    for (int d = 0; d < M; d++) begin
      terms[d+1] = ACC_W'(pd2[d]);
    end
    for (int j = 0; j < NP; j++) begin
      part_next[j] = terms[2*j] + terms[2*j+1];
    end
  end

  always_comb begin
    total = '0;
    for (int j = 0; j < NP; j++) begin
      total = total + part3[j];
    end
    rounded = total + HALF;
    quot    = rounded >>> FRAC;
    if (quot > SMAX) begin
      sat = SMAX[W-1:0];
    end else if (quot < SMIN) begin
      sat = SMIN[W-1:0];
    end else begin
      sat = quot[W-1:0];
    end
  end

endmodule

// ===== rtl/core/savitzky_golay_smoothing_filter.sv =====
// Streaming symmetric Savitzky-Golay smoother for signed samples. One sample
// is accepted per clock while the issue sequencer is idle or issuing its last
// pending result. Each result is issued, one per clock while the multiply
// pipeline takes it, into its job, product, partial-sum and output registers.
// The first H samples of a series come out raw at once, the next H are held,
// and from then on each sample releases the filtered value centered H samples
// back. A sample marked as the end of a series releases up to H+1 results, one
// per clock while the pipeline takes them, and holds off the input until the
// last is issued. Half widths outside 2..MAX_HALF_WIDTH are clamped.
// Coefficients are signed Q2.14; each filtered sum is rounded to nearest with
// ties upward and saturated to the sample range. The user must write registers
// through the configuration port only while the block is idle; it is not enforced.
module savitzky_golay_smoothing_filter #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_HALF_WIDTH = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sgf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [sgf_pkg::COEF_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic                                  end_of_series,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         smoothed_value,
  output logic                                  was_filtered,
  output logic                                  last_of_series
);

  localparam int CIB = sgf_pkg::CFG_IDX_BITS;

  logic [sgf_pkg::HW_BITS-1:0]           half_width;
  logic signed [sgf_pkg::COEF_BITS-1:0]  coef_center;
  logic signed [sgf_pkg::COEF_BITS-1:0]  coef_dist [sgf_pkg::NUM_DIST];
  logic signed [sgf_pkg::COEF_BITS-1:0]  coef_used [MAX_HALF_WIDTH];
  logic [CIB-1:0]                        dist_idx;

  logic                                  job_valid;
  logic                                  job_ready;
  sgf_pkg::job_flags_t                   job_flags;
  logic signed [SAMPLE_BITS-1:0]         job_raw;
  logic signed [SAMPLE_BITS-1:0]         job_center;
  logic signed [SAMPLE_BITS:0]           job_psum [MAX_HALF_WIDTH];

  assign cfg_ready = 1'b1;
  assign dist_idx  = cfg_index - CIB'(sgf_pkg::REG_COEF_DIST1);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= sgf_pkg::HALF_WIDTH_RESET;
      coef_center <= sgf_pkg::COEF_CENTER_RESET;
      for (int d = 0; d < sgf_pkg::NUM_DIST; d++) begin
        coef_dist[d] <= sgf_pkg::COEF_DIST_RESET[d];
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        sgf_pkg::REG_HALF_WIDTH: begin
          half_width <= cfg_data[sgf_pkg::HW_BITS-1:0];
        end
        sgf_pkg::REG_COEF_CENTER: begin
          coef_center <= cfg_data;
        end
        [sgf_pkg::REG_COEF_DIST1:sgf_pkg::REG_COEF_DIST6]: begin
          coef_dist[dist_idx] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_HALF_WIDTH; d++) begin
      coef_used[d] = coef_dist[d];
    end
  end

  sgf_ctrl #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .half_width    (half_width),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .end_of_series (end_of_series),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job_flags     (job_flags),
    .job_raw       (job_raw),
    .job_center    (job_center),
    .job_psum      (job_psum)
  );

  sgf_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_mac (
    .clk            (clk),
    .rst            (rst),
    .coef_center    (coef_center),
    .coef_dist      (coef_used),
    .job_valid      (job_valid),
    .job_ready      (job_ready),
    .job_flags      (job_flags),
    .job_raw        (job_raw),
    .job_center     (job_center),
    .job_psum       (job_psum),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smoothed_value (smoothed_value),
    .was_filtered   (was_filtered),
    .last_of_series (last_of_series)
  );

endmodule

// ===== bench/savitzky_golay_smoothing_filter_tb.sv =====
`timescale 1ns / 100ps

module savitzky_golay_smoothing_filter_tb;

  localparam int WINDOW_DEPTH = 13;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int TARGET_ITEMS = 330;

  typedef struct packed {
    logic signed [15:0] value;
    logic filtered;
    logic last;
  } smooth_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sgf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [sgf_pkg::COEF_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample = '0;
  logic end_of_series = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] smoothed_value;
  logic was_filtered;
  logic last_of_series;

  logic signed [15:0] sample_window [WINDOW_DEPTH];
  int unsigned series_len;
  logic [2:0] hw_setting;
  logic signed [15:0] coef_mirror [7];
  smooth_out_t pending_out [$];
  smooth_out_t oldest;

  int failures = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int unsigned ready_span = 0;
  int unsigned ready_mode = 0;

  savitzky_golay_smoothing_filter u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .end_of_series(end_of_series),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .smoothed_value(smoothed_value),
    .was_filtered(was_filtered),
    .last_of_series(last_of_series)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_half_width();
    int unsigned h;
    h = hw_setting;
    if (h < 2) h = 2;
    if (h > 6) h = 6;
    return h;
  endfunction

  function automatic logic [15:0] filtered_at(int unsigned h);
    longint acc;
    int unsigned d;
    acc = longint'(coef_mirror[0]) * longint'(sample_window[h]);
    for (d = 1; d <= h; d++)
      acc += longint'(coef_mirror[d]) *
             (longint'(sample_window[h - d]) + longint'(sample_window[h + d]));
    acc = (acc + 64'sd8192) >>> 14;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  function automatic void push_out(logic [15:0] v, logic f, logic l);
    smooth_out_t r;
    r.value = v;
    r.filtered = f;
    r.last = l;
    pending_out = {pending_out, r};
  endfunction

  function automatic void smooth_sample(logic signed [15:0] s, logic eos);
    int unsigned h;
    int unsigned i;
    int k;
    int first;
    h = active_half_width();
    i = series_len;
    for (k = WINDOW_DEPTH - 1; k > 0; k--) sample_window[k] = sample_window[k - 1];
    sample_window[0] = s;
    if (!eos) begin
      if (i < h) push_out(sample_window[0], 1'b0, 1'b0);
      else if (i >= 2 * h) push_out(filtered_at(h), 1'b1, 1'b0);
      series_len = (i < WINDOW_DEPTH) ? i + 1 : WINDOW_DEPTH;
    end else begin
      if (i < 2 * h) begin
        first = (i < h) ? 0 : int'(i - h);
        for (k = first; k >= 0; k--) push_out(sample_window[k], 1'b0, k == 0);
      end else begin
        push_out(filtered_at(h), 1'b1, 1'b0);
        for (k = int'(h) - 1; k >= 0; k--) push_out(sample_window[k], 1'b0, k == 0);
      end
      series_len = 0;
    end
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] half_width_word(logic [2:0] h);
    return (16'($urandom) & 16'hfff8) | 16'(h);
  endfunction

  task automatic send_sample(input logic [15:0] value, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    sample <= value;
    end_of_series <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    smooth_sample(value, last);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sgf_pkg::cfg_reg_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == sgf_pkg::REG_HALF_WIDTH) hw_setting = value[2:0];
    else coef_mirror[int'(idx) - 1] = value;
    @(posedge clk);
  endtask

  task automatic check_reset_coefficients();
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hffff, 1'b1);
  endtask

  task automatic check_short_series();
    send_sample(16'h8000, 1'b1);
    send_sample(16'd5, 1'b0);
    send_sample(16'd6, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd8, 1'b1);
  endtask

  task automatic check_rounding_and_saturation();
    settle();
    write_reg(sgf_pkg::REG_COEF_CENTER, 16'd8192);
    write_reg(sgf_pkg::REG_COEF_DIST1, 16'd0);
    write_reg(sgf_pkg::REG_COEF_DIST2, 16'd0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b1);
    settle();
    write_reg(sgf_pkg::REG_COEF_CENTER, 16'h7fff);
    write_reg(sgf_pkg::REG_COEF_DIST1, 16'h7fff);
    write_reg(sgf_pkg::REG_COEF_DIST2, 16'h8000);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b1);
  endtask

  task automatic check_mid_series_half_width();
    settle();
    write_reg(sgf_pkg::REG_HALF_WIDTH, half_width_word(3'd2));
    send_sample(16'd11, 1'b0);
    send_sample(16'd22, 1'b0);
    send_sample(16'd33, 1'b0);
    settle();
    write_reg(sgf_pkg::REG_HALF_WIDTH, half_width_word(3'd6));
    send_sample(16'd44, 1'b1);
    send_sample(16'hff00, 1'b0);
    send_sample(16'h0100, 1'b0);
    send_sample(16'hfe00, 1'b0);
    settle();
    write_reg(sgf_pkg::REG_HALF_WIDTH, half_width_word(3'd2));
    send_sample(16'h0200, 1'b1);
  endtask

  task automatic load_random_settings(input int phase);
    int k;
    logic [2:0] h;
    settle();
    if (phase == 0) h = 3'd7;
    else if (phase == 1) h = 3'd0;
    else h = 3'($urandom_range(0, 7));
    write_reg(sgf_pkg::REG_HALF_WIDTH, half_width_word(h));
    for (k = 1; k < 8; k++) begin
      if (phase == 0) write_reg(sgf_pkg::cfg_reg_t'(k), 16'h7fff);
      else if (phase == 1) write_reg(sgf_pkg::cfg_reg_t'(k), 16'h8000);
      else write_reg(sgf_pkg::cfg_reg_t'(k), pick_coef());
    end
  endtask

  task automatic check_random_series();
    int phase;
    int unsigned h;
    int unsigned len;
    int unsigned change_at;
    int k;
    int series_left;
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      load_random_settings(phase);
      phase++;
      series_left = $urandom_range(3, 6);
      while (series_left > 0 && items_sent < TARGET_ITEMS) begin
        series_left--;
        h = active_half_width();
        if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 2 * h);
        else len = $urandom_range(2 * h + 1, 2 * h + 24);
        change_at = ($urandom_range(0, 7) == 0 && len > 2) ? $urandom_range(1, len - 1) : 0;
        for (k = 0; k < int'(len); k++) begin
          if (change_at != 0 && k == int'(change_at)) begin
            settle();
            write_reg(sgf_pkg::REG_HALF_WIDTH, half_width_word(3'($urandom_range(0, 7))));
          end
          send_sample(pick_sample(), k == int'(len) - 1);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_span <= $urandom_range(8, 48);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 4) != 0);
      default: out_ready <= (ready_span % 6) >= 4;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: expected none, actual value %0d filtered %b last %b",
                 $time, smoothed_value, was_filtered, last_of_series);
      end else begin
        oldest = pending_out.pop_front();
        if (smoothed_value !== oldest.value) begin
          failures++;
          $display("%0t: smoothed_value expected %0d actual %0d",
                   $time, oldest.value, smoothed_value);
        end
        if (was_filtered !== oldest.filtered) begin
          failures++;
          $display("%0t: was_filtered expected %b actual %b",
                   $time, oldest.filtered, was_filtered);
        end
        if (last_of_series !== oldest.last) begin
          failures++;
          $display("%0t: last_of_series expected %b actual %b",
                   $time, oldest.last, last_of_series);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("savitzky_golay_smoothing_filter verification failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < WINDOW_DEPTH; k++) sample_window[k] = '0;
    series_len = 0;
    hw_setting = sgf_pkg::HALF_WIDTH_RESET;
    coef_mirror[0] = sgf_pkg::COEF_CENTER_RESET;
    for (int k = 1; k < 7; k++) coef_mirror[k] = sgf_pkg::COEF_DIST_RESET[k - 1];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    check_reset_coefficients();
    check_short_series();
    check_rounding_and_saturation();
    check_mid_series_half_width();
    check_random_series();
    settle();
    if (failures == 0 && pending_out.size() == 0) begin
      $display("savitzky_golay_smoothing_filter verification clean");
    end else begin
      $display("savitzky_golay_smoothing_filter verification failed");
    end
    $finish;
  end

endmodule
